// File: rtl/bcd_pkg.sv
// Shared types and constants for the button click detector.
// No dependencies; bcd_front, bcd_queue, bcd_back and the core import this package.
`default_nettype none

package bcd_pkg;

  localparam int TICK_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 3;
  localparam int REPEAT_W       = 4;
  localparam int NUM_EVENTS     = 7;

  typedef enum logic [2:0] {
    EV_DOWN       = 3'd0,
    EV_UP         = 3'd1,
    EV_REPEAT     = 3'd2,
    EV_SINGLE     = 3'd3,
    EV_DOUBLE     = 3'd4,
    EV_LONG_START = 3'd5,
    EV_LONG_HOLD  = 3'd6
  } ev_code_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_LEVEL  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_LEN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_LIMIT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EVENT_ENABLE = 3'd4;

  // All events raised by one tick, at most two, in the order they leave.
  typedef struct packed {
    ev_code_t              ev0_code;
    logic [REPEAT_W-1:0]   ev0_repeat;
    ev_code_t              ev1_code;
    logic [REPEAT_W-1:0]   ev1_repeat;
    logic                  has_two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

endpackage

`default_nettype wire

// File: rtl/bcd_in_if.sv
// Input channel of the button click detector: one pin sample per word.
// Uses no package.
`default_nettype none

interface bcd_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

// File: rtl/bcd_out_if.sv
// Output channel of the button click detector: one event per word.
// Uses no package.
`default_nettype none

interface bcd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic [3:0] repeat_count;
  logic       last;

  modport source (output valid, output event_code, output repeat_count, output last,
                  input ready);
  modport sink   (input valid, input event_code, input repeat_count, input last,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/bcd_front.sv
// Front end: configuration registers, debouncer and the press state machine.
// Depends on bcd_pkg; produces one queue entry per accepted tick that raises an enabled event.
`default_nettype none

module bcd_front #(
  parameter int TICK_WIDTH = bcd_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bcd_pkg::cfg_write_t  cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 pin_level,
  input  wire bcd_pkg::q_status_t   q_status,
  output logic                      push,
  output bcd_pkg::entry_t           push_entry
);
  import bcd_pkg::*;

  localparam int CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_HELD     = 3'd1,
    ST_RELEASED = 3'd2,
    ST_AGAIN    = 3'd3,
    ST_LONG     = 3'd5
  } state_t;

  logic                  press_level;
  logic [2:0]            settle_len;
  logic [15:0]           short_limit;
  logic [15:0]           long_limit;
  logic [NUM_EVENTS-1:0] event_enable;

  state_t                state, state_next;
  logic [TICK_WIDTH-1:0] tick_count, tick_count_next, tick_inc;
  logic [REPEAT_W-1:0]   click_total, click_total_next;
  logic [2:0]            bounce_count, bounce_count_next, bounce_inc;
  logic                  stable_level, stable_level_next;

  logic                  pressed, accept;
  logic [CMP_W-1:0]      tick_ext, short_ext, long_ext;
  logic                  a_on, b_on, a_en, b_en;
  ev_code_t              a_code, b_code;
  logic [REPEAT_W-1:0]   a_rep, b_rep;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    tick_inc = (state != ST_IDLE) ? tick_count + 1'b1 : tick_count;
    bounce_inc = bounce_count + 3'd1;
    stable_level_next = stable_level;
    if (pin_level != stable_level) begin
      if (bounce_inc >= settle_len) begin
        stable_level_next = pin_level;
        bounce_count_next = 3'd0;
      end else begin
        bounce_count_next = bounce_inc;
      end
    end else begin
      bounce_count_next = 3'd0;
    end
    pressed = (stable_level_next == press_level);

    tick_ext  = CMP_W'(tick_inc);
    short_ext = CMP_W'(short_limit);
    long_ext  = CMP_W'(long_limit);

    state_next       = state;
    tick_count_next  = tick_inc;
    click_total_next = click_total;
    a_on   = 1'b0;
    b_on   = 1'b0;
    a_code = EV_DOWN;
    b_code = EV_REPEAT;
    a_rep  = click_total;
    b_rep  = click_total;

    case (state)
      ST_IDLE: begin
        if (pressed) begin
          a_on             = 1'b1;
          a_code           = EV_DOWN;
          tick_count_next  = '0;
          click_total_next = REPEAT_W'(1);
          state_next       = ST_HELD;
        end
      end
      ST_HELD: begin
        if (!pressed) begin
          a_on            = 1'b1;
          a_code          = EV_UP;
          tick_count_next = '0;
          state_next      = ST_RELEASED;
        end else if (tick_ext > long_ext) begin
          a_on       = 1'b1;
          a_code     = EV_LONG_START;
          state_next = ST_LONG;
        end
      end
      ST_RELEASED: begin
        if (pressed) begin
          // Press down carries the old count, the repeat event the new one.
          a_on             = 1'b1;
          a_code           = EV_DOWN;
          click_total_next = click_total + 1'b1;
          b_on             = 1'b1;
          b_code           = EV_REPEAT;
          b_rep            = click_total + 1'b1;
          tick_count_next  = '0;
          state_next       = ST_AGAIN;
        end else if (tick_ext > short_ext) begin
          if (click_total == REPEAT_W'(1)) begin
            a_on   = 1'b1;
            a_code = EV_SINGLE;
          end else if (click_total == REPEAT_W'(2)) begin
            a_on   = 1'b1;
            a_code = EV_DOUBLE;
          end
          state_next = ST_IDLE;
        end
      end
      ST_AGAIN: begin
        if (!pressed) begin
          a_on   = 1'b1;
          a_code = EV_UP;
          if (tick_ext < short_ext) begin
            tick_count_next = '0;
            state_next      = ST_RELEASED;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (tick_ext > short_ext) begin
          state_next = ST_IDLE;
        end
      end
      ST_LONG: begin
        a_on = 1'b1;
        if (pressed) begin
          a_code = EV_LONG_HOLD;
        end else begin
          a_code     = EV_UP;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    a_en = a_on && event_enable[a_code];
    b_en = b_on && event_enable[b_code];

    push_entry.ev0_code   = a_en ? a_code : b_code;
    push_entry.ev0_repeat = a_en ? a_rep : b_rep;
    push_entry.ev1_code   = b_code;
    push_entry.ev1_repeat = b_rep;
    push_entry.has_two    = a_en && b_en;
    push = accept && (a_en || b_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_level  <= 1'b0;
      settle_len   <= 3'd3;
      short_limit  <= 16'd60;
      long_limit   <= 16'd200;
      event_enable <= '1;
      state        <= ST_IDLE;
      tick_count   <= '0;
      click_total  <= '0;
      bounce_count <= '0;
      stable_level <= 1'b1;
    end else begin
      if (accept) begin
        state        <= state_next;
        tick_count   <= tick_count_next;
        click_total  <= click_total_next;
        bounce_count <= bounce_count_next;
      end
      // Writing the pressed level reloads the stable level with its inverse.
      if (cfg.we && (cfg.index == CFG_PRESS_LEVEL)) begin
        stable_level <= !cfg.data[0];
      end else if (accept) begin
        stable_level <= stable_level_next;
      end
      if (cfg.we) begin
        case (cfg.index)
          CFG_PRESS_LEVEL:  press_level  <= cfg.data[0];
          CFG_SETTLE_LEN:   settle_len   <= cfg.data[2:0];
          CFG_SHORT_LIMIT:  short_limit  <= cfg.data[15:0];
          CFG_LONG_LIMIT:   long_limit   <= cfg.data[15:0];
          CFG_EVENT_ENABLE: event_enable <= cfg.data[NUM_EVENTS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bcd_queue.sv
// Short FIFO of event entries between the front end and the output stage.
// Depends on bcd_pkg for the entry and status types.
`default_nettype none

module bcd_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire bcd_pkg::entry_t    push_entry,
  input  wire logic               pop,
  output bcd_pkg::entry_t         head,
  output bcd_pkg::q_status_t      status
);
  import bcd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || pop))
    else $error("entry pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("entry popped from an empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue fill count did not follow a push");

endmodule

`default_nettype wire

// File: rtl/bcd_back.sv
// Output stage: takes entries from the queue and sends their events one word at a time.
// Depends on bcd_pkg for the entry and status types.
`default_nettype none

module bcd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bcd_pkg::entry_t    head,
  input  wire bcd_pkg::q_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              event_code,
  output logic [3:0]              repeat_count,
  output logic                    last
);
  import bcd_pkg::*;

  entry_t hold;
  logic   hold_valid;
  logic   phase;
  logic   out_accept;

  assign out_valid    = hold_valid;
  assign last         = hold.has_two ? phase : 1'b1;
  assign event_code   = phase ? hold.ev1_code : hold.ev0_code;
  assign repeat_count = phase ? hold.ev1_repeat : hold.ev0_repeat;
  assign out_accept   = out_valid && out_ready;
  // The next entry moves in on the same edge that the last event of this one leaves.
  assign pop          = !q_status.empty && (!hold_valid || (out_accept && last));

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= 1'b0;
    end else begin
      if (pop) begin
        hold_valid <= 1'b1;
        phase      <= 1'b0;
      end else if (out_accept) begin
        if (last) begin
          hold_valid <= 1'b0;
          phase      <= 1'b0;
        end else begin
          phase <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/button_click_detector_core.sv
// Button click detector. Each input word is one pin sample (one tick); a tick
// is accepted in every cycle while the four-entry event queue has room. Each
// tick raises zero, one or two events; the output stage sends one event word per
// cycle while the output side is ready, so a tick with two events leaves as two
// words, and the queue absorbs such bursts and any stall on the output side. The
// first event of a tick passes through the queue and then the output stage's
// hold register. Configuration writes are registered and apply to later ticks.
// Depends on bcd_pkg, bcd_in_if, bcd_out_if, bcd_front, bcd_queue and bcd_back.
`default_nettype none

module button_click_detector_core #(
  parameter int TICK_WIDTH = bcd_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  bcd_in_if.sink                                pin_ch,
  bcd_out_if.source                             event_ch,
  input  wire logic                             cfg_we,
  input  wire logic [bcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bcd_pkg::*;

  cfg_write_t cfg;
  q_status_t  q_status;
  entry_t     push_entry, head;
  logic       push, pop;
  logic       in_ready;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;
  assign pin_ch.ready = in_ready;

  bcd_front #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (pin_ch.valid),
    .in_ready   (in_ready),
    .pin_level  (pin_ch.pin_level),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  bcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  bcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (event_ch.valid),
    .out_ready    (event_ch.ready),
    .event_code   (event_ch.event_code),
    .repeat_count (event_ch.repeat_count),
    .last         (event_ch.last)
  );

endmodule

`default_nettype wire
